@@ hdl/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared constants, command codes and control/status types of the waypoint
// path follower.
// ----------------------------------------------------------------------------
package wpf_pkg;

    // waypoint queue
    localparam int WAYPOINT_DEPTH = 16;
    localparam int QIDX_W         = $clog2(WAYPOINT_DEPTH);
    localparam int QCNT_W         = $clog2(WAYPOINT_DEPTH + 1);

    // arithmetic widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;     // difference of two positions
    localparam int MAG_W   = POS_W;         // |difference| fits in 32 bits
    localparam int PROD_W  = 64;
    localparam int SQ_W    = 65;            // dx^2 + dy^2
    localparam int RAD_W   = 66;            // radicand padded to even width
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIVN_W  = 56;            // dividend / quotient
    localparam int DIVD_W  = 33;            // divisor
    localparam int SPEED_W = 24;
    localparam int DUR_W   = 16;
    localparam int DT_W    = 16;
    localparam int ELAP_W  = 17;
    localparam int FRAC_W  = 16;
    localparam int S_W     = 17;

    localparam logic [SPEED_W-1:0] SPEED_RESET  = 24'd25600;
    localparam logic [DUR_W-1:0]   DUR_RESET    = 16'd1966;
    localparam logic [ELAP_W-1:0]  ELAPSED_MAX  = 17'h1FFFF;
    localparam logic [17:0]        SMOOTH_K     = 18'd196608;   // 3.0 in Q.16

    // item modes
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_MOVE  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_CORR  = 2'd3;

    // register indexes
    localparam logic REG_MOVE_SPEED = 1'b0;
    localparam logic REG_CORR_DUR   = 1'b1;

    // datapath commands
    localparam int OP_W = 6;
    localparam logic [OP_W-1:0] OP_NONE   = 6'd0;
    localparam logic [OP_W-1:0] OP_LATCH  = 6'd1;
    localparam logic [OP_W-1:0] OP_PUSH   = 6'd2;
    localparam logic [OP_W-1:0] OP_START  = 6'd3;
    localparam logic [OP_W-1:0] OP_CACC   = 6'd4;
    localparam logic [OP_W-1:0] OP_BUDGET = 6'd5;
    localparam logic [OP_W-1:0] OP_BSET   = 6'd6;
    localparam logic [OP_W-1:0] OP_RDHEAD = 6'd7;
    localparam logic [OP_W-1:0] OP_DIFF   = 6'd8;
    localparam logic [OP_W-1:0] OP_SQX    = 6'd9;
    localparam logic [OP_W-1:0] OP_SQY    = 6'd10;
    localparam logic [OP_W-1:0] OP_SQSUM  = 6'd11;
    localparam logic [OP_W-1:0] OP_SQRT   = 6'd12;
    localparam logic [OP_W-1:0] OP_ARRIVE = 6'd13;
    localparam logic [OP_W-1:0] OP_VZERO  = 6'd14;
    localparam logic [OP_W-1:0] OP_MULX_B = 6'd15;
    localparam logic [OP_W-1:0] OP_MULY_B = 6'd16;
    localparam logic [OP_W-1:0] OP_MULX_S = 6'd17;
    localparam logic [OP_W-1:0] OP_MULY_S = 6'd18;
    localparam logic [OP_W-1:0] OP_DIVD   = 6'd19;
    localparam logic [OP_W-1:0] OP_ADDPX  = 6'd20;
    localparam logic [OP_W-1:0] OP_ADDPY  = 6'd21;
    localparam logic [OP_W-1:0] OP_SETVX  = 6'd22;
    localparam logic [OP_W-1:0] OP_SETVY  = 6'd23;
    localparam logic [OP_W-1:0] OP_CEND   = 6'd24;
    localparam logic [OP_W-1:0] OP_TDIV   = 6'd25;
    localparam logic [OP_W-1:0] OP_TSET   = 6'd26;
    localparam logic [OP_W-1:0] OP_TT     = 6'd27;
    localparam logic [OP_W-1:0] OP_S1     = 6'd28;
    localparam logic [OP_W-1:0] OP_SSET   = 6'd29;
    localparam logic [OP_W-1:0] OP_CDIFF  = 6'd30;
    localparam logic [OP_W-1:0] OP_MULX_C = 6'd31;
    localparam logic [OP_W-1:0] OP_MULY_C = 6'd32;
    localparam logic [OP_W-1:0] OP_CPX    = 6'd33;
    localparam logic [OP_W-1:0] OP_CPY    = 6'd34;
    localparam logic [OP_W-1:0] OP_OUT    = 6'd35;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cnt_zero;
        logic       budget_zero;
        logic       budget_ge_dist;
        logic       dist_zero;
        logic       in_corr;
        logic       elapsed_ge_dur;
        logic       div_done;
        logic       sqrt_done;
    } dp_status_t;

endpackage

@@ hdl/wpf_div.sv @@
// ----------------------------------------------------------------------------
// wpf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpf_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [wpf_pkg::DIVN_W-1:0] dividend,
    input  logic [wpf_pkg::DIVD_W-1:0] divisor,
    output logic [wpf_pkg::DIVN_W-1:0] quotient,
    output logic                       done
);
    import wpf_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] div_reg;
    logic [DIVD_W:0]   remx;
    logic              fits;

    assign remx = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits = (remx >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DIVN_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIVN_W-2:0], fits};
            if (fits) begin
                rem_reg <= DIVD_W'(remx - {1'b0, div_reg});
            end else begin
                rem_reg <= remx[DIVD_W-1:0];
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ hdl/wpf_sqrt.sv @@
// ----------------------------------------------------------------------------
// wpf_sqrt
// Integer square root (floor), one root bit per cycle.
// ----------------------------------------------------------------------------
module wpf_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [wpf_pkg::RAD_W-1:0]  radicand,
    output logic [wpf_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    import wpf_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 1;

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  remx;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign remx  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = (remx >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(ROOT_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            if (fits) begin
                rem_reg <= REM_W'(remx - trial);
            end else begin
                rem_reg <= remx[REM_W-1:0];
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

@@ hdl/wpf_dp.sv @@
// ----------------------------------------------------------------------------
// wpf_dp
// Datapath: motion state, waypoint queue memory, shared multiplier, divider
// and square root, driven one command per cycle.
// ----------------------------------------------------------------------------
module wpf_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wpf_pkg::dp_cmd_t            cmd,
    output wpf_pkg::dp_status_t         status,
    input  logic [wpf_pkg::SPEED_W-1:0] move_speed,
    input  logic [wpf_pkg::DUR_W-1:0]   corr_dur,
    input  logic [1:0]                  in_mode,
    input  logic [31:0]                 in_x,
    input  logic [31:0]                 in_y,
    input  logic [wpf_pkg::DT_W-1:0]    in_dt,
    output logic [31:0]                 out_pos_x,
    output logic [31:0]                 out_pos_y,
    output logic [31:0]                 out_vel_x,
    output logic [31:0]                 out_vel_y,
    output logic [4:0]                  out_left,
    output logic                        out_corr,
    output logic                        out_dropped
);
    import wpf_pkg::*;

    // queue memory
    logic [POS_W-1:0] qx_mem [WAYPOINT_DEPTH];
    logic [POS_W-1:0] qy_mem [WAYPOINT_DEPTH];

    // architectural state
    logic [QIDX_W-1:0]  head_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [POS_W-1:0]   vel_x_reg, vel_y_reg;
    logic [POS_W-1:0]   start_x_reg, start_y_reg;
    logic [POS_W-1:0]   tgt_x_reg, tgt_y_reg;
    logic               in_corr_reg;
    logic [ELAP_W-1:0]  elapsed_reg;

    // working registers
    logic [1:0]         mode_reg;
    logic [POS_W-1:0]   cx_reg, cy_reg;
    logic [DT_W-1:0]    dt_reg;
    logic               dropped_reg;
    logic [SPEED_W-1:0] budget_reg;
    logic [POS_W-1:0]   wp_x_reg, wp_y_reg;
    logic [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [ROOT_W-1:0]  dist_reg;
    logic               neg_reg;
    logic [FRAC_W-1:0]  t_reg;
    logic [S_W-1:0]     s_reg;

    // output registers
    logic [POS_W-1:0]   o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    logic [4:0]         o_left_reg;
    logic               o_corr_reg, o_drop_reg;

    logic [MAG_W-1:0]   mag_x, mag_y;
    logic [DIFF_W-1:0]  neg_dx, neg_dy;
    logic [31:0]        mul_a, mul_b;
    logic [PROD_W-1:0]  prod_next;
    logic [QIDX_W:0]    tail_sum;
    logic [QIDX_W-1:0]  tail;
    logic [QIDX_W-1:0]  head_inc;
    logic               full;
    logic [ELAP_W:0]    elap_sum;
    logic [17:0]        smooth_b;
    logic [31:0]        div_q32, div_sv;
    logic [31:0]        corr_q, corr_sv;

    logic               div_start, sqrt_start;
    logic [DIVN_W-1:0]  div_n, div_quo;
    logic [DIVD_W-1:0]  div_d;
    logic               div_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic               sqrt_done;

    assign neg_dx = ~dx_reg + 1'b1;
    assign neg_dy = ~dy_reg + 1'b1;
    assign mag_x  = dx_reg[DIFF_W-1] ? neg_dx[MAG_W-1:0] : dx_reg[MAG_W-1:0];
    assign mag_y  = dy_reg[DIFF_W-1] ? neg_dy[MAG_W-1:0] : dy_reg[MAG_W-1:0];

    assign tail_sum = (QIDX_W+1)'(head_reg) + (QIDX_W+1)'(count_reg);
    assign tail     = (tail_sum >= (QIDX_W+1)'(WAYPOINT_DEPTH))
                    ? QIDX_W'(tail_sum - (QIDX_W+1)'(WAYPOINT_DEPTH))
                    : tail_sum[QIDX_W-1:0];
    assign head_inc = (head_reg == QIDX_W'(WAYPOINT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign full     = (count_reg == QCNT_W'(WAYPOINT_DEPTH));

    assign elap_sum = (ELAP_W+1)'(elapsed_reg) + (ELAP_W+1)'(dt_reg);
    assign smooth_b = SMOOTH_K - {1'b0, t_reg, 1'b0};

    assign div_q32 = div_quo[31:0];
    assign div_sv  = neg_reg ? (~div_q32 + 1'b1) : div_q32;
    assign corr_q  = prod_reg[47:16];
    assign corr_sv = neg_reg ? (~corr_q + 1'b1) : corr_q;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_BUDGET: begin
                mul_a = 32'(move_speed);
                mul_b = 32'(dt_reg);
            end
            OP_SQX: begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            OP_SQY: begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            OP_MULX_B: begin
                mul_a = mag_x;
                mul_b = 32'(budget_reg);
            end
            OP_MULY_B: begin
                mul_a = mag_y;
                mul_b = 32'(budget_reg);
            end
            OP_MULX_S: begin
                mul_a = mag_x;
                mul_b = 32'(move_speed);
            end
            OP_MULY_S: begin
                mul_a = mag_y;
                mul_b = 32'(move_speed);
            end
            OP_TT: begin
                mul_a = 32'(t_reg);
                mul_b = 32'(t_reg);
            end
            OP_S1: begin
                mul_a = prod_reg[31:0];
                mul_b = 32'(smooth_b);
            end
            OP_MULX_C: begin
                mul_a = mag_x;
                mul_b = 32'(s_reg);
            end
            OP_MULY_C: begin
                mul_a = mag_y;
                mul_b = 32'(s_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_start  = (cmd.op == OP_DIVD) || (cmd.op == OP_TDIV);
    assign div_n      = (cmd.op == OP_TDIV) ? DIVN_W'({elapsed_reg, 16'h0000})
                                            : prod_reg[DIVN_W-1:0];
    assign div_d      = (cmd.op == OP_TDIV) ? DIVD_W'(corr_dur) : dist_reg;
    assign sqrt_start = (cmd.op == OP_SQRT);

    wpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_quo),
        .done     (div_done)
    );

    wpf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({1'b0, sq_reg}),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    // queue memory, registered read of the head entry
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PUSH && !full) begin
            qx_mem[tail] <= cx_reg;
            qy_mem[tail] <= cy_reg;
        end
        if (cmd.op == OP_RDHEAD) begin
            wp_x_reg <= qx_mem[head_reg];
            wp_y_reg <= qy_mem[head_reg];
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            tgt_x_reg   <= '0;
            tgt_y_reg   <= '0;
            in_corr_reg <= 1'b0;
            elapsed_reg <= '0;
        end else begin
            case (cmd.op)
                OP_PUSH: begin
                    if (!full) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_START: begin
                    start_x_reg <= pos_x_reg;
                    start_y_reg <= pos_y_reg;
                    tgt_x_reg   <= cx_reg;
                    tgt_y_reg   <= cy_reg;
                    elapsed_reg <= '0;
                    in_corr_reg <= 1'b1;
                end
                OP_CACC: begin
                    elapsed_reg <= elap_sum[ELAP_W] ? ELAPSED_MAX : elap_sum[ELAP_W-1:0];
                end
                OP_ARRIVE: begin
                    pos_x_reg <= wp_x_reg;
                    pos_y_reg <= wp_y_reg;
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                OP_VZERO: begin
                    vel_x_reg <= '0;
                    vel_y_reg <= '0;
                end
                OP_ADDPX: pos_x_reg <= pos_x_reg + div_sv;
                OP_ADDPY: pos_y_reg <= pos_y_reg + div_sv;
                OP_SETVX: vel_x_reg <= div_sv;
                OP_SETVY: vel_y_reg <= div_sv;
                OP_CEND: begin
                    pos_x_reg   <= tgt_x_reg;
                    pos_y_reg   <= tgt_y_reg;
                    in_corr_reg <= 1'b0;
                end
                OP_CPX: pos_x_reg <= start_x_reg + corr_sv;
                OP_CPY: pos_y_reg <= start_y_reg + corr_sv;
                default: begin
                end
            endcase
        end
    end

    // working and output registers
    always_ff @(posedge aclk) begin
        if (sqrt_done) begin
            dist_reg <= sqrt_root;
        end
        case (cmd.op)
            OP_LATCH: begin
                mode_reg    <= in_mode;
                cx_reg      <= in_x;
                cy_reg      <= in_y;
                dt_reg      <= in_dt;
                dropped_reg <= 1'b0;
            end
            OP_PUSH:   dropped_reg <= full;
            OP_BUDGET: prod_reg <= prod_next;
            OP_BSET:   budget_reg <= prod_reg[SPEED_W+15:16];
            OP_DIFF: begin
                dx_reg <= {wp_x_reg[POS_W-1], wp_x_reg} - {pos_x_reg[POS_W-1], pos_x_reg};
                dy_reg <= {wp_y_reg[POS_W-1], wp_y_reg} - {pos_y_reg[POS_W-1], pos_y_reg};
            end
            OP_SQX: prod_reg <= prod_next;
            OP_SQY: begin
                sq_reg   <= {1'b0, prod_reg};
                prod_reg <= prod_next;
            end
            OP_SQSUM:  sq_reg <= sq_reg + {1'b0, prod_reg};
            OP_ARRIVE: budget_reg <= budget_reg - dist_reg[SPEED_W-1:0];
            OP_MULX_B, OP_MULX_S, OP_MULX_C: begin
                prod_reg <= prod_next;
                neg_reg  <= dx_reg[DIFF_W-1];
            end
            OP_MULY_B, OP_MULY_S, OP_MULY_C: begin
                prod_reg <= prod_next;
                neg_reg  <= dy_reg[DIFF_W-1];
            end
            OP_TSET: t_reg <= div_quo[FRAC_W-1:0];
            OP_TT:   prod_reg <= prod_next;
            OP_S1:   prod_reg <= prod_next;
            OP_SSET: s_reg <= prod_reg[32+S_W-1:32];
            OP_CDIFF: begin
                dx_reg <= {tgt_x_reg[POS_W-1], tgt_x_reg}
                        - {start_x_reg[POS_W-1], start_x_reg};
                dy_reg <= {tgt_y_reg[POS_W-1], tgt_y_reg}
                        - {start_y_reg[POS_W-1], start_y_reg};
            end
            OP_OUT: begin
                o_px_reg   <= pos_x_reg;
                o_py_reg   <= pos_y_reg;
                o_vx_reg   <= vel_x_reg;
                o_vy_reg   <= vel_y_reg;
                o_left_reg <= 5'(count_reg);
                o_corr_reg <= in_corr_reg;
                o_drop_reg <= dropped_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.mode           = mode_reg;
        status.cnt_zero       = (count_reg == '0);
        status.budget_zero    = (budget_reg == '0);
        status.budget_ge_dist = (ROOT_W'(budget_reg) >= dist_reg);
        status.dist_zero      = (dist_reg == '0);
        status.in_corr        = in_corr_reg;
        status.elapsed_ge_dur = (elapsed_reg >= ELAP_W'(corr_dur));
        status.div_done       = div_done;
        status.sqrt_done      = sqrt_done;
    end

    assign out_pos_x   = o_px_reg;
    assign out_pos_y   = o_py_reg;
    assign out_vel_x   = o_vx_reg;
    assign out_vel_y   = o_vy_reg;
    assign out_left    = o_left_reg;
    assign out_corr    = o_corr_reg;
    assign out_dropped = o_drop_reg;

endmodule

@@ hdl/wpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// wpf_ctrl
// Sequencer: walks each item through the datapath and runs the handshakes.
// ----------------------------------------------------------------------------
module wpf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wpf_pkg::dp_status_t status,
    output wpf_pkg::dp_cmd_t    cmd
);
    import wpf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_BSET  = 5'd2;
    localparam logic [4:0] S_MLOOP = 5'd3;
    localparam logic [4:0] S_DIFF  = 5'd4;
    localparam logic [4:0] S_SQX   = 5'd5;
    localparam logic [4:0] S_SQY   = 5'd6;
    localparam logic [4:0] S_SQSUM = 5'd7;
    localparam logic [4:0] S_SQRT  = 5'd8;
    localparam logic [4:0] S_SQW   = 5'd9;
    localparam logic [4:0] S_DEC   = 5'd10;
    localparam logic [4:0] S_ARR2  = 5'd11;
    localparam logic [4:0] S_MUL   = 5'd12;
    localparam logic [4:0] S_DIVGO = 5'd13;
    localparam logic [4:0] S_DIVW  = 5'd14;
    localparam logic [4:0] S_APPLY = 5'd15;
    localparam logic [4:0] S_CCHK  = 5'd16;
    localparam logic [4:0] S_TW    = 5'd17;
    localparam logic [4:0] S_TSET  = 5'd18;
    localparam logic [4:0] S_TT    = 5'd19;
    localparam logic [4:0] S_S1    = 5'd20;
    localparam logic [4:0] S_SSET  = 5'd21;
    localparam logic [4:0] S_CD    = 5'd22;
    localparam logic [4:0] S_CMX   = 5'd23;
    localparam logic [4:0] S_CPX   = 5'd24;
    localparam logic [4:0] S_CMY   = 5'd25;
    localparam logic [4:0] S_CPY   = 5'd26;
    localparam logic [4:0] S_FIN   = 5'd27;

    // scale steps: position x, position y, velocity x, velocity y
    localparam logic [1:0] K_PX = 2'd0;
    localparam logic [1:0] K_PY = 2'd1;
    localparam logic [1:0] K_VX = 2'd2;
    localparam logic [1:0] K_VY = 2'd3;

    logic [4:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       aim_reg, aim_next;     // distance is for aiming, not a reach test
    logic       part_reg, part_next;   // partial move: tick ends after scaling
    logic       mv_reg, mv_next;
    logic       out_free;

    assign out_free = !mv_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        aim_next   = aim_reg;
        part_next  = part_reg;
        mv_next    = mv_reg && !m_ready;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    part_next  = 1'b0;
                    aim_next   = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (status.mode)
                    MODE_PUSH: begin
                        cmd.op     = OP_PUSH;
                        state_next = S_FIN;
                    end
                    MODE_MOVE: begin
                        cmd.op     = OP_BUDGET;
                        state_next = S_BSET;
                    end
                    MODE_START: begin
                        cmd.op     = OP_START;
                        state_next = S_FIN;
                    end
                    default: begin
                        if (status.in_corr) begin
                            cmd.op     = OP_CACC;
                            state_next = S_CCHK;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                endcase
            end
            S_BSET: begin
                cmd.op     = OP_BSET;
                state_next = S_MLOOP;
            end
            S_MLOOP: begin
                if (status.budget_zero || status.cnt_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.op     = OP_RDHEAD;
                    aim_next   = 1'b0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = S_SQX;
            end
            S_SQX: begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.op     = OP_SQY;
                state_next = S_SQSUM;
            end
            S_SQSUM: begin
                cmd.op     = OP_SQSUM;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op     = OP_SQRT;
                state_next = S_SQW;
            end
            S_SQW: begin
                if (status.sqrt_done) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (aim_reg) begin
                    if (status.dist_zero) begin
                        cmd.op     = OP_VZERO;
                        state_next = S_MLOOP;
                    end else begin
                        step_next  = K_VX;
                        state_next = S_MUL;
                    end
                end else if (status.budget_ge_dist) begin
                    cmd.op     = OP_ARRIVE;
                    state_next = S_ARR2;
                end else begin
                    part_next  = 1'b1;
                    step_next  = K_PX;
                    state_next = S_MUL;
                end
            end
            S_ARR2: begin
                if (status.cnt_zero) begin
                    cmd.op     = OP_VZERO;
                    state_next = S_MLOOP;
                end else begin
                    cmd.op     = OP_RDHEAD;
                    aim_next   = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_MUL: begin
                case (step_reg)
                    K_PX:    cmd.op = OP_MULX_B;
                    K_PY:    cmd.op = OP_MULY_B;
                    K_VX:    cmd.op = OP_MULX_S;
                    default: cmd.op = OP_MULY_S;
                endcase
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                cmd.op     = OP_DIVD;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (status.div_done) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                case (step_reg)
                    K_PX:    cmd.op = OP_ADDPX;
                    K_PY:    cmd.op = OP_ADDPY;
                    K_VX:    cmd.op = OP_SETVX;
                    default: cmd.op = OP_SETVY;
                endcase
                if (step_reg == K_VY) begin
                    state_next = part_reg ? S_FIN : S_MLOOP;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_CCHK: begin
                if (status.elapsed_ge_dur) begin
                    cmd.op     = OP_CEND;
                    state_next = S_FIN;
                end else begin
                    cmd.op     = OP_TDIV;
                    state_next = S_TW;
                end
            end
            S_TW: begin
                if (status.div_done) begin
                    state_next = S_TSET;
                end
            end
            S_TSET: begin
                cmd.op     = OP_TSET;
                state_next = S_TT;
            end
            S_TT: begin
                cmd.op     = OP_TT;
                state_next = S_S1;
            end
            S_S1: begin
                cmd.op     = OP_S1;
                state_next = S_SSET;
            end
            S_SSET: begin
                cmd.op     = OP_SSET;
                state_next = S_CD;
            end
            S_CD: begin
                cmd.op     = OP_CDIFF;
                state_next = S_CMX;
            end
            S_CMX: begin
                cmd.op     = OP_MULX_C;
                state_next = S_CPX;
            end
            S_CPX: begin
                cmd.op     = OP_CPX;
                state_next = S_CMY;
            end
            S_CMY: begin
                cmd.op     = OP_MULY_C;
                state_next = S_CPY;
            end
            S_CPY: begin
                cmd.op     = OP_CPY;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.op     = OP_OUT;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= K_PX;
            aim_reg   <= 1'b0;
            part_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            aim_reg   <= aim_next;
            part_reg  <= part_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

endmodule

@@ hdl/waypoint_path_follower.sv @@
// ----------------------------------------------------------------------------
// waypoint_path_follower
// 2D waypoint follower with a smoothstep position correction, APB registers.
// ----------------------------------------------------------------------------
// Every item gives exactly one result item. Items are worked one at a time;
// a finished result waits in the output register while the next item is
// taken in. Push and start-correction items use neither serial unit; a
// correction tick runs the serial divider once to form the time fraction.
// A move tick runs the serial square root once per distance check and the
// divider once per scaled axis: two checks and two axes per waypoint reached
// with another waypoint behind it, and one check and four axes for the final
// partial step. Registers: move_speed at 0x0 (24 bit, Q16.8 per second),
// correction_duration at 0x4 (16 bit, Q0.16 s); write them only while no item
// is in flight. The waypoint queue holds WAYPOINT_DEPTH entries; a push into
// a full queue is dropped and flagged on its result.
// ----------------------------------------------------------------------------
module waypoint_path_follower (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic [15:0]        s_delta_time,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic [4:0]         m_waypoints_left,
    output logic               m_correcting,
    output logic               m_push_dropped
);
    import wpf_pkg::*;

    logic [SPEED_W-1:0] speed_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic               cfg_wr;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [31:0]        px, py, vx, vy;

    // register file: word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= SPEED_RESET;
            dur_reg   <= DUR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MOVE_SPEED) begin
                speed_reg <= pwdata[SPEED_W-1:0];
            end else begin
                dur_reg <= pwdata[DUR_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CORR_DUR) ? 32'(dur_reg) : 32'(speed_reg);

    // sequencer
    wpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // motion datapath
    wpf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .move_speed  (speed_reg),
        .corr_dur    (dur_reg),
        .in_mode     (s_mode),
        .in_x        (s_coord_x),
        .in_y        (s_coord_y),
        .in_dt       (s_delta_time),
        .out_pos_x   (px),
        .out_pos_y   (py),
        .out_vel_x   (vx),
        .out_vel_y   (vy),
        .out_left    (m_waypoints_left),
        .out_corr    (m_correcting),
        .out_dropped (m_push_dropped)
    );

    assign m_pos_x = signed'(px);
    assign m_pos_y = signed'(py);
    assign m_vel_x = signed'(vx);
    assign m_vel_y = signed'(vy);

endmodule

@@ tb/tb_waypoint_path_follower.sv @@
// ----------------------------------------------------------------------------
// tb_waypoint_path_follower
// Self-checking bench: a queue-fed driver pushes path items (waypoint pushes,
// move ticks, correction starts and ticks) through the valid/ready input
// while an internal fixed-point path model predicts each result. A monitor
// compares every result field by field. APB writes change speed and
// correction length between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb_waypoint_path_follower;
    import wpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = 16;

    // register byte addresses
    localparam logic [2:0] ADDR_SPEED = {REG_MOVE_SPEED, 2'b00};
    localparam logic [2:0] ADDR_DUR   = {REG_CORR_DUR, 2'b00};

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [15:0] dt;
    } path_item_t;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [4:0]  left;
        logic        corr;
        logic        drop;
    } track_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_PUSH;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic [15:0] s_delta_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;
    logic [4:0]  m_waypoints_left;
    logic        m_correcting;
    logic        m_push_dropped;

    waypoint_path_follower dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Path model: its own copy of state and configuration
    // ------------------------------------------------------------------
    longint            wp_x [QDEPTH];
    longint            wp_y [QDEPTH];
    int                wp_head = 0;
    int                wp_count = 0;
    longint            cur_x = 0, cur_y = 0;
    longint            vel_x = 0, vel_y = 0;
    longint            from_x = 0, from_y = 0;
    longint            goal_x = 0, goal_y = 0;
    bit                correcting = 0;
    longint unsigned   corr_time = 0;
    longint unsigned   speed_cfg = 25600;
    longint unsigned   dur_cfg = 1966;

    path_item_t        pending_items[$];
    track_state_t      expected_track[$];
    path_item_t        held;
    int                gap_left = 0;
    int                stall_left = 0;
    bit                burst = 0;

    int n_items = 0, n_results = 0, n_mismatch = 0;
    int n_dropped = 0, n_arrivals = 0, n_corr_done = 0;

    // floor of the euclidean distance, exact on the 66-bit sum of squares
    function automatic longint unsigned path_dist(longint dx, longint dy);
        longint unsigned a, b, rem, root;
        logic [65:0] sum;
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        sum = {2'b00, a * a} + {2'b00, b * b};
        rem = 0;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | longint'(sum[2*i +: 2]);
            if (rem >= ((root << 2) | 1)) begin
                rem = rem - ((root << 2) | 1);
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // (d * m) / div, truncated toward zero
    function automatic longint scale_tz(longint d, longint unsigned m,
                                        longint unsigned div);
        longint unsigned mg, q;
        mg = (d < 0) ? -d : d;
        q = mg * m / div;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void aim(longint dx, longint dy, longint unsigned d);
        if (d == 0) begin
            vel_x = 0;
            vel_y = 0;
        end else begin
            vel_x = scale_tz(dx, speed_cfg, d);
            vel_y = scale_tz(dy, speed_cfg, d);
        end
    endfunction

    function automatic void advance_path(longint unsigned dt);
        longint unsigned budget, d;
        longint dx, dy, nx, ny;
        budget = (speed_cfg * dt) >> 16;
        while (budget > 0 && wp_count > 0) begin
            dx = wp_x[wp_head] - cur_x;
            dy = wp_y[wp_head] - cur_y;
            d = path_dist(dx, dy);
            if (budget >= d) begin
                cur_x = wp_x[wp_head];
                cur_y = wp_y[wp_head];
                budget -= d;
                wp_head = (wp_head + 1) % QDEPTH;
                wp_count--;
                n_arrivals++;
                if (wp_count > 0) begin
                    nx = wp_x[wp_head] - cur_x;
                    ny = wp_y[wp_head] - cur_y;
                    aim(nx, ny, path_dist(nx, ny));
                end else begin
                    vel_x = 0;
                    vel_y = 0;
                end
            end else begin
                cur_x += scale_tz(dx, budget, d);
                cur_y += scale_tz(dy, budget, d);
                aim(dx, dy, d);
                break;
            end
        end
    endfunction

    function automatic void advance_correction(longint unsigned dt);
        longint unsigned t, s;
        if (!correcting) return;
        corr_time += dt;
        if (corr_time > 131071) corr_time = 131071;
        if (corr_time >= dur_cfg) begin
            cur_x = goal_x;
            cur_y = goal_y;
            correcting = 0;
            n_corr_done++;
            return;
        end
        t = (corr_time << 16) / dur_cfg;
        s = (t * t * (196608 - 2 * t)) >> 32;
        cur_x = from_x + scale_tz(goal_x - from_x, s, 65536);
        cur_y = from_y + scale_tz(goal_y - from_y, s, 65536);
    endfunction

    // apply one accepted item and queue the result it must produce
    function automatic void track_item(path_item_t it);
        track_state_t r;
        bit drop;
        drop = 0;
        case (it.mode)
            MODE_PUSH: begin
                if (wp_count >= QDEPTH) begin
                    drop = 1;
                    n_dropped++;
                end else begin
                    wp_x[(wp_head + wp_count) % QDEPTH] = longint'($signed(it.cx));
                    wp_y[(wp_head + wp_count) % QDEPTH] = longint'($signed(it.cy));
                    wp_count++;
                end
            end
            MODE_MOVE: advance_path(it.dt);
            MODE_START: begin
                from_x = cur_x;
                from_y = cur_y;
                goal_x = longint'($signed(it.cx));
                goal_y = longint'($signed(it.cy));
                corr_time = 0;
                correcting = 1;
            end
            default: advance_correction(it.dt);
        endcase
        r.px = 32'(cur_x);
        r.py = 32'(cur_y);
        r.vx = 32'(vel_x);
        r.vy = 32'(vel_y);
        r.left = 5'(wp_count);
        r.corr = correcting;
        r.drop = drop;
        expected_track.push_back(r);
    endfunction

    // mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds items from pending_items, holds valid until accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_item(held);
                n_items++;
            end
            if ($urandom_range(0, 199) == 0) burst = !burst;
            if (s_valid && !s_ready) begin
                // holding the current item
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                held = pending_items[0];
                pending_items.delete(0);
                s_mode       <= held.mode;
                s_coord_x    <= held.cx;
                s_coord_y    <= held.cy;
                s_delta_time <= held.dt;
                s_valid      <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        track_state_t e;
        bit bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_track.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result with nothing expected", $realtime);
                end else begin
                    e = expected_track[0];
                    expected_track.delete(0);
                    bad = (m_pos_x !== e.px) || (m_pos_y !== e.py) ||
                          (m_vel_x !== e.vx) || (m_vel_y !== e.vy) ||
                          (m_waypoints_left !== e.left) ||
                          (m_correcting !== e.corr) || (m_push_dropped !== e.drop);
                    if (bad) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("%0t: result %0d mismatch: exp pos %h,%h vel %h,%h left %0d corr %b drop %b",
                                     $realtime, n_results, e.px, e.py, e.vx, e.vy,
                                     e.left, e.corr, e.drop);
                            $display("    got pos %h,%h vel %h,%h left %0d corr %b drop %b",
                                     m_pos_x, m_pos_y, m_vel_x, m_vel_y,
                                     m_waypoints_left, m_correcting, m_push_dropped);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_item(logic [1:0] mode, logic [31:0] cx, logic [31:0] cy,
                                     logic [15:0] dt);
        path_item_t it;
        it.mode = mode;
        it.cx = cx;
        it.cy = cy;
        it.dt = dt;
        pending_items.push_back(it);
    endfunction

    // coordinate inside a box around the origin (Q24.8)
    function automatic logic [31:0] box_coord();
        int span;
        span = ($urandom_range(0, 3) == 0) ? 4096 : 40000;
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [15:0] tick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 6) return 16'($urandom_range(0, 4000));
        return 16'($urandom);
    endfunction

    // well-formed path sequences with random content, plus some noise
    task automatic add_random(int n);
        int made, r, k;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                k = $urandom_range(1, 4);
                repeat (k) add_item(MODE_PUSH, box_coord(), box_coord(), 16'($urandom));
                made += k;
            end else if (r < 60) begin
                add_item(MODE_MOVE, $urandom, $urandom, tick_len());
                made++;
            end else if (r < 70) begin
                k = $urandom_range(1, 4);
                if ($urandom_range(0, 3) == 0)
                    add_item(MODE_START, $urandom, $urandom, 16'($urandom));
                else
                    add_item(MODE_START, box_coord(), box_coord(), 16'($urandom));
                repeat (k) add_item(MODE_CORR, $urandom, $urandom, tick_len());
                made += k + 1;
            end else if (r < 80) begin
                add_item(MODE_CORR, $urandom, $urandom, tick_len());
                made++;
            end else if (r < 90) begin
                // pull the position back near the origin
                add_item(MODE_START, box_coord(), box_coord(), 16'($urandom));
                add_item(MODE_CORR, $urandom, $urandom, 16'hFFFF);
                made += 2;
            end else begin
                add_item(2'($urandom_range(1, 3)), $urandom, $urandom, 16'($urandom));
                made++;
            end
        end
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SPEED) speed_cfg = data & 32'hFFFFFF;
        else dur_cfg = data & 32'hFFFF;
    endtask

    // wait until every queued item went in and every result came back
    task automatic drain();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_track.size() != 0);
        repeat (20) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle tick, empty move, zero-length hop, extremes, full queue
        add_item(MODE_CORR, 32'h0, 32'h0, 16'd100);
        add_item(MODE_MOVE, 32'h0, 32'h0, 16'hFFFF);
        add_item(MODE_PUSH, 32'h0, 32'h0, 16'h0);
        add_item(MODE_PUSH, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
        add_item(MODE_MOVE, 32'h0, 32'h0, 16'h0);
        add_item(MODE_MOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        add_item(MODE_START, 32'h80000000, 32'h7FFFFFFF, 16'h0);
        add_item(MODE_CORR, 32'h0, 32'h0, 16'd1);
        add_item(MODE_CORR, 32'h0, 32'h0, 16'd900);
        add_item(MODE_START, 32'h7FFFFFFF, 32'h80000000, 16'h0);
        add_item(MODE_CORR, 32'h0, 32'h0, 16'hFFFF);
        add_item(MODE_MOVE, 32'h0, 32'h0, 16'd1);
        for (int i = 0; i < 13; i++)
            add_item(MODE_PUSH, 32'h7FFFFF00 - 32'(i * 256), 32'h80000000, 16'h0);
        // queue now holds 14; fill it and overflow twice
        add_item(MODE_PUSH, 32'h7FFFF000, 32'h80000000, 16'h0);
        add_item(MODE_PUSH, 32'h7FFFF100, 32'h80000100, 16'h0);
        add_item(MODE_PUSH, 32'h7FFFF200, 32'h80000200, 16'h0);
        add_item(MODE_PUSH, 32'h0, 32'h0, 16'h0);
        drain();
        // clear the queue in one fast tick before the random part
        reg_write(ADDR_SPEED, 32'hFFFFFF);
        add_item(MODE_MOVE, 32'h0, 32'h0, 16'hFFFF);
        add_item(MODE_START, 32'h0, 32'h0, 16'h0);
        add_item(MODE_CORR, 32'h0, 32'h0, 16'hFFFF);
        drain();
        reg_write(ADDR_SPEED, 32'd25600);
        reg_write(ADDR_DUR, 32'd1966);
        add_random(230);
        drain();

        // fastest speed, shortest correction
        reg_write(ADDR_SPEED, 32'hFFFFFF);
        reg_write(ADDR_DUR, 32'd1);
        add_random(200);
        drain();

        // zero move speed, longest correction
        reg_write(ADDR_SPEED, 32'd0);
        reg_write(ADDR_DUR, 32'hFFFF);
        add_random(150);
        drain();

        // random settings
        reg_write(ADDR_SPEED, 32'($urandom_range(1, 131072)));
        reg_write(ADDR_DUR, 32'($urandom_range(1, 65535)));
        add_random(125);
        drain();
        reg_write(ADDR_SPEED, 32'($urandom_range(0, 24'hFFFFFF)));
        reg_write(ADDR_DUR, 32'($urandom_range(1, 8000)));
        add_random(125);
        drain();

        $display("run covered %0d items, %0d results, %0d waypoints reached,",
                 n_items, n_results, n_arrivals);
        $display("%0d dropped pushes and %0d finished corrections over 6 settings",
                 n_dropped, n_corr_done);
        if (n_mismatch == 0 && expected_track.size() == 0) begin
            $display("waypoint_path_follower verification clean");
        end else begin
            $display("waypoint_path_follower verification failed");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #200ms;
        $display("waypoint_path_follower verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/wpf_pkg.sv
hdl/wpf_div.sv
hdl/wpf_sqrt.sv
hdl/wpf_dp.sv
hdl/wpf_ctrl.sv
hdl/waypoint_path_follower.sv
tb/tb_waypoint_path_follower.sv
